@@ sv/swmm_pkg.sv @@
// shared types, constants and codes for the sliding window multiset match unit
package swmm_pkg;

  localparam int WINDOW_MAX = 256;
  localparam int VALUE_BITS = 10;

  localparam int TABLE_DEPTH = 1 << VALUE_BITS;
  localparam int VAL_W       = 10;
  localparam int CNT_W       = 9;
  localparam int GOOD_W      = 32;
  localparam int CFG_W       = 9;
  localparam int CFG_IDX_W   = 2;
  localparam int LEN_W       = $clog2(WINDOW_MAX + 1);
  localparam int POS_W       = $clog2(WINDOW_MAX);
  localparam int CMP_W       = (LEN_W > CFG_W) ? LEN_W : CFG_W;
  localparam int WIDE_W      = (VALUE_BITS > VAL_W) ? VALUE_BITS : VAL_W;

  localparam logic [CNT_W-1:0]  COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [GOOD_W-1:0] GOOD_MAX  = {GOOD_W{1'b1}};

  // command codes
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_LOAD   = 2'd1;
  localparam logic [1:0] CMD_STREAM = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_MATCHES   = 2'd1;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [VAL_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic              window_good;
    logic [CNT_W-1:0]  matched_count;
    logic [GOOD_W-1:0] good_windows;
  } result_t;

  typedef enum logic [1:0] {
    OP_ENTER,
    OP_LEAVE,
    OP_LOAD
  } count_op_t;

  typedef struct packed {
    logic [CNT_W-1:0] count_next;
    logic             count_we;
    logic [CNT_W-1:0] match_next;
  } count_upd_t;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_LD_RD,
    S_LD_WR,
    S_ENT_RD,
    S_ENT_WR,
    S_LV_RD,
    S_LV_WR
  } state_t;

endpackage

@@ sv/swmm_ram.sv @@
// generic single port ram with registered read
module swmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ sv/swmm_count_unit.sv @@
// shared saturating count and match update used for enter, leave and load
module swmm_count_unit (
  input  swmm_pkg::count_op_t             op,
  input  logic [swmm_pkg::CNT_W-1:0]      need,
  input  logic [swmm_pkg::CNT_W-1:0]      count,
  input  logic [swmm_pkg::CNT_W-1:0]      match,
  output swmm_pkg::count_upd_t            upd
);
  import swmm_pkg::*;

  logic [CNT_W-1:0] inc_sat;
  logic [CNT_W-1:0] dec;

  assign inc_sat = (count < COUNT_MAX) ? count + CNT_W'(1) : count;
  assign dec     = count - CNT_W'(1);

  always_comb begin
    upd.count_next = count;
    upd.count_we   = 1'b0;
    upd.match_next = match;
    unique case (op)
      OP_ENTER: begin
        if (need != '0) begin
          upd.count_next = inc_sat;
          upd.count_we   = 1'b1;
          if (inc_sat <= need && match < COUNT_MAX) begin
            upd.match_next = match + CNT_W'(1);
          end
        end
      end
      OP_LEAVE: begin
        if (need != '0 && count != '0) begin
          upd.count_next = dec;
          upd.count_we   = 1'b1;
          if (dec < need && match != '0) begin
            upd.match_next = match - CNT_W'(1);
          end
        end
      end
      OP_LOAD: begin
        upd.count_next = inc_sat;
        upd.count_we   = 1'b1;
      end
      default: begin
        upd.count_we = 1'b0;
      end
    endcase
  end

endmodule

@@ sv/sliding_window_multiset_match_unit.sv @@
// top level: sequencer, count tables, window delay line and result register
//
// channel  | dir | handshake                   | payload
// item     | in  | item_valid / item_ready     | cmd, value
// result   | out | result_valid / result_ready | window_good, matched_count, good_windows
// cfg      | in  | cfg_valid / cfg_ready       | cfg_index, cfg_data
//
// a stream item is a read then a write of the entering value's count in the
// single-port count tables through the shared count unit; once the window is
// full the leaving value adds one more read before its write
// a load is a read then a write of the need table, a clear sweeps both tables
// after reset the same clearing pass runs before item_ready rises
// a result waits in its output register; the block only stalls at the end of
// a stream item when the previous result has not been taken yet
module sliding_window_multiset_match_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  swmm_pkg::item_t                     item,
  output logic                                result_valid,
  input  logic                                result_ready,
  output swmm_pkg::result_t                   result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [swmm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [swmm_pkg::CFG_W-1:0]          cfg_data
);
  import swmm_pkg::*;

  state_t state, state_next;

  // latched item
  logic [VALUE_BITS-1:0] val_q;
  logic [VALUE_BITS-1:0] leaving;
  logic                  leave_en;

  // window bookkeeping
  logic [LEN_W-1:0]      fill_count;
  logic [CNT_W-1:0]      match_total;
  logic [GOOD_W-1:0]     good_total;
  logic [POS_W-1:0]      write_pos;
  logic [VALUE_BITS-1:0] clr_addr;

  // configuration
  logic [CFG_W-1:0]      window_length;
  logic [CFG_W-1:0]      min_matches;
  logic [LEN_W-1:0]      len_eff;
  logic [CMP_W-1:0]      len_wide;

  // ram ports
  logic [VALUE_BITS-1:0] tbl_addr;
  logic                  nt_we, wt_we;
  logic [CNT_W-1:0]      nt_wdata, wt_wdata;
  logic [CNT_W-1:0]      nt_rdata, wt_rdata;
  logic [POS_W-1:0]      dl_addr;
  logic                  dl_we;
  logic [VALUE_BITS-1:0] dl_rdata;
  logic [POS_W-1:0]      old_pos;
  logic [LEN_W:0]        old_pos_wide;

  // shared count unit
  count_op_t             cu_op;
  logic [CNT_W-1:0]      cu_count;
  count_upd_t            cu_upd;

  logic [WIDE_W-1:0]     val_wide;
  logic                  window_full;
  logic                  out_free;

  // result payload, built from the counts after the leave
  logic [CNT_W-1:0]      match_final;
  logic                  good_final;
  logic [GOOD_W-1:0]     good_total_next;

  // zero means one, anything above the window maximum is clamped
  assign len_wide = CMP_W'(window_length);
  always_comb begin
    if (window_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_wide > CMP_W'(WINDOW_MAX)) begin
      len_eff = LEN_W'(WINDOW_MAX);
    end else begin
      len_eff = len_wide[LEN_W-1:0];
    end
  end

  // position of the value that leaves, len places behind the write position
  always_comb begin
    if ((LEN_W + 1)'(write_pos) >= (LEN_W + 1)'(len_eff)) begin
      old_pos_wide = (LEN_W + 1)'(write_pos) - (LEN_W + 1)'(len_eff);
    end else begin
      old_pos_wide = (LEN_W + 1)'(write_pos) + (LEN_W + 1)'(WINDOW_MAX)
                     - (LEN_W + 1)'(len_eff);
    end
  end
  assign old_pos = old_pos_wide[POS_W-1:0];

  assign val_wide    = WIDE_W'(item.value);
  assign window_full = fill_count >= len_eff;
  assign out_free    = !result_valid || result_ready;
  assign cfg_ready   = (state == S_IDLE);
  assign item_ready  = (state == S_IDLE);

  // configuration registers, written only while idle
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= CFG_W'(1);
      min_matches   <= CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_WINDOW_LENGTH) begin
        window_length <= cfg_data;
      end else if (cfg_index == REG_MIN_MATCHES) begin
        min_matches <= cfg_data;
      end
    end
  end

  // count tables and delay line
  swmm_ram #(.WIDTH(CNT_W), .DEPTH(TABLE_DEPTH)) u_needed (
    .clk   (clk),
    .addr  (tbl_addr),
    .we    (nt_we),
    .wdata (nt_wdata),
    .rdata (nt_rdata)
  );

  swmm_ram #(.WIDTH(CNT_W), .DEPTH(TABLE_DEPTH)) u_window (
    .clk   (clk),
    .addr  (tbl_addr),
    .we    (wt_we),
    .wdata (wt_wdata),
    .rdata (wt_rdata)
  );

  swmm_ram #(.WIDTH(VALUE_BITS), .DEPTH(WINDOW_MAX)) u_delay (
    .clk   (clk),
    .addr  (dl_addr),
    .we    (dl_we),
    .wdata (val_q),
    .rdata (dl_rdata)
  );

  swmm_count_unit u_count (
    .op    (cu_op),
    .need  (nt_rdata),
    .count (cu_count),
    .match (match_total),
    .upd   (cu_upd)
  );

  assign cu_count = (cu_op == OP_LOAD) ? nt_rdata : wt_rdata;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  // next state, ram control and count unit operation
  always_comb begin
    state_next = state;
    tbl_addr   = val_q;
    nt_we      = 1'b0;
    wt_we      = 1'b0;
    nt_wdata   = cu_upd.count_next;
    wt_wdata   = cu_upd.count_next;
    dl_addr    = write_pos;
    dl_we      = 1'b0;
    cu_op      = OP_ENTER;
    unique case (state)
      S_CLR: begin
        tbl_addr = clr_addr;
        nt_we    = 1'b1;
        wt_we    = 1'b1;
        nt_wdata = '0;
        wt_wdata = '0;
        if (clr_addr == {VALUE_BITS{1'b1}}) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (item_valid) begin
          unique case (item.cmd)
            CMD_CLEAR:  state_next = S_CLR;
            CMD_LOAD:   state_next = S_LD_RD;
            CMD_STREAM: state_next = S_ENT_RD;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_LD_RD: begin
        state_next = S_LD_WR;
      end
      S_LD_WR: begin
        cu_op      = OP_LOAD;
        nt_we      = cu_upd.count_we;
        state_next = S_IDLE;
      end
      S_ENT_RD: begin
        dl_addr    = old_pos;
        state_next = S_ENT_WR;
      end
      S_ENT_WR: begin
        cu_op      = OP_ENTER;
        wt_we      = cu_upd.count_we;
        dl_we      = 1'b1;
        state_next = window_full ? S_LV_RD : S_LV_WR;
      end
      S_LV_RD: begin
        tbl_addr   = leaving;
        state_next = S_LV_WR;
      end
      S_LV_WR: begin
        // also the result step; a window still filling skips the leave
        tbl_addr = leaving;
        cu_op    = OP_LEAVE;
        wt_we    = leave_en && cu_upd.count_we;
        if (!window_full) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign match_final     = leave_en ? cu_upd.match_next : match_total;
  assign good_final      = match_final >= min_matches;
  assign good_total_next = (good_final && good_total != GOOD_MAX)
                           ? good_total + GOOD_W'(1) : good_total;

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count   <= '0;
      match_total  <= '0;
      good_total   <= '0;
      write_pos    <= '0;
      clr_addr     <= '0;
      leave_en     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      // a new result may replace the one taken in the same cycle
      if (state == S_LV_WR && window_full && out_free) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          clr_addr <= clr_addr + VALUE_BITS'(1);
        end
        S_IDLE: begin
          if (item_valid) begin
            val_q <= val_wide[VALUE_BITS-1:0];
            if (item.cmd == CMD_CLEAR) begin
              fill_count  <= '0;
              match_total <= '0;
              good_total  <= '0;
              write_pos   <= '0;
              clr_addr    <= '0;
            end
          end
        end
        S_ENT_WR: begin
          match_total <= cu_upd.match_next;
          leaving     <= dl_rdata;
          leave_en    <= window_full;
          if (!window_full) begin
            fill_count <= fill_count + LEN_W'(1);
          end
          if (write_pos == POS_W'(WINDOW_MAX - 1)) begin
            write_pos <= '0;
          end else begin
            write_pos <= write_pos + POS_W'(1);
          end
        end
        S_LV_WR: begin
          if (leave_en) begin
            match_total <= cu_upd.match_next;
          end
          if (leave_en) begin
            leave_en <= 1'b0;
          end
          if (window_full && out_free) begin
            // good total is committed with the result transfer into the register
            good_total <= good_total_next;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result <= '0;
    end else if (state == S_LV_WR && window_full && out_free) begin
      result.window_good   <= good_final;
      result.matched_count <= match_final;
      result.good_windows  <= good_total_next;
    end
  end

endmodule

@@ test/testbench.sv @@
// self-checking testbench for the sliding window multiset match unit
module testbench;
  import swmm_pkg::*;

  // the one command code the block ignores
  localparam logic [1:0] CMD_SPARE = 2'd3;

  localparam int QUIET_CYCLES   = 1100;   // long enough for a clear to sweep both tables
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS   = 250;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic    item_valid = 1'b0;
  logic    item_ready;
  item_t   item = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // no idling on either side while set
  logic steady = 1'b0;

  sliding_window_multiset_match_unit dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // window match predictor: own copy of tables, delay line and registers
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]  need_count   [TABLE_DEPTH];
  logic [CNT_W-1:0]  window_count [TABLE_DEPTH];
  logic [VAL_W-1:0]  history      [WINDOW_MAX];
  int                fill_level;
  int                write_slot;
  logic [CNT_W-1:0]  match_level;
  logic [GOOD_W-1:0] good_level;
  logic [CFG_W-1:0]  len_reg;
  logic [CFG_W-1:0]  min_reg;

  result_t pending_windows [$];

  int fault_count = 0;
  int sent = 0;
  int n_stream = 0, n_load = 0, n_clear = 0, n_spare = 0;
  int n_windows = 0, n_good = 0;
  int quiet_run = 0;

  task automatic log_error(input string msg);
    if (fault_count < 40) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    fault_count++;
  endtask

  function automatic void wipe_case();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      need_count[i]   = '0;
      window_count[i] = '0;
    end
    fill_level  = 0;
    write_slot  = 0;
    match_level = '0;
    good_level  = '0;
  endfunction

  // entering value: only values with a nonzero need are tracked
  function automatic void count_in(input logic [VAL_W-1:0] v);
    if (need_count[v] != '0) begin
      if (window_count[v] != COUNT_MAX) window_count[v] = window_count[v] + 1'b1;
      if (window_count[v] <= need_count[v] && match_level != COUNT_MAX) begin
        match_level = match_level + 1'b1;
      end
    end
  endfunction

  // leaving value: removed only while its window count is nonzero
  function automatic void count_out(input logic [VAL_W-1:0] v);
    if (need_count[v] != '0 && window_count[v] != '0) begin
      window_count[v] = window_count[v] - 1'b1;
      if (window_count[v] < need_count[v] && match_level != '0) begin
        match_level = match_level - 1'b1;
      end
    end
  endfunction

  function automatic void stream_value(input logic [VAL_W-1:0] v);
    int      span;
    int      back;
    result_t win;
    span = (len_reg == '0) ? 1 : (len_reg > WINDOW_MAX) ? WINDOW_MAX : int'(len_reg);
    // entering value first, then the one span positions back leaves
    count_in(v);
    if (fill_level >= span) begin
      back = (write_slot >= span) ? write_slot - span : write_slot + WINDOW_MAX - span;
      count_out(history[back]);
    end else begin
      fill_level++;
    end
    history[write_slot] = v;
    write_slot = (write_slot + 1) % WINDOW_MAX;
    if (fill_level >= span) begin
      win.window_good = (match_level >= min_reg);
      if (win.window_good && good_level != GOOD_MAX) good_level = good_level + 1'b1;
      win.matched_count = match_level;
      win.good_windows  = good_level;
      pending_windows = {pending_windows, win};
    end
  endfunction

  // ---------------------------------------------------------------------------
  // scoreboard: checks result transfers, then tracks config and item transfers
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    result_t want;
    if (rst) begin
      wipe_case();
      for (int i = 0; i < WINDOW_MAX; i++) history[i] = '0;
      len_reg = 9'd1;
      min_reg = 9'd1;
    end else begin
      if (result_valid && result_ready) begin
        n_windows++;
        if (result.window_good) n_good++;
        if (pending_windows.size() == 0) begin
          log_error("result transfer with no window pending");
        end else begin
          want = pending_windows.pop_front();
          if (result.window_good !== want.window_good)
            log_error($sformatf("window_good got %0b want %0b",
                                result.window_good, want.window_good));
          if (result.matched_count !== want.matched_count)
            log_error($sformatf("matched_count got %0d want %0d",
                                result.matched_count, want.matched_count));
          if (result.good_windows !== want.good_windows)
            log_error($sformatf("good_windows got %0d want %0d",
                                result.good_windows, want.good_windows));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WINDOW_LENGTH: len_reg = cfg_data;
          REG_MIN_MATCHES:   min_reg = cfg_data;
          default: ;
        endcase
      end
      if (item_valid && item_ready) begin
        case (item.cmd)
          CMD_CLEAR: begin
            n_clear++;
            wipe_case();
          end
          CMD_LOAD: begin
            n_load++;
            if (need_count[item.value] != COUNT_MAX)
              need_count[item.value] = need_count[item.value] + 1'b1;
          end
          CMD_STREAM: begin
            n_stream++;
            stream_value(item.value);
          end
          default: n_spare++;
        endcase
      end
    end
  end

  // receiver side: stalls about a third of the time unless steady
  always @(posedge clk) begin
    result_ready <= steady || ($urandom_range(0, 99) >= 33);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_run <= 0;
    end else begin
      quiet_run <= quiet_run + 1;
      if (quiet_run >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // driving tasks
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [1:0] op, input logic [VAL_W-1:0] v);
    item_t pkt;
    pkt.cmd   = op;
    pkt.value = v;
    if (!steady && $urandom_range(0, 99) < 33) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= pkt;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sent++;
  endtask

  // sender holds off until every pending window has come back and the block is idle
  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_windows.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reconfigure(input logic [CFG_W-1:0] len, input logic [CFG_W-1:0] need);
    settle();
    write_reg(REG_WINDOW_LENGTH, len);
    write_reg(REG_MIN_MATCHES, need);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset registers: one-value windows, one match needed
  task automatic test_basics();
    send_item(CMD_STREAM, 10'd0);          // nothing loaded yet
    send_item(CMD_LOAD, 10'd1023);
    send_item(CMD_LOAD, 10'd0);
    send_item(CMD_STREAM, 10'd1023);
    send_item(CMD_STREAM, 10'd0);
    send_item(CMD_STREAM, 10'd5);          // value with no need
    send_item(CMD_SPARE, 10'd1023);        // ignored command
    send_item(CMD_CLEAR, 10'd1023);        // value ignored on clear
    send_item(CMD_STREAM, 10'd1023);       // need wiped by the clear
  endtask

  // repeated values beyond their need, load during streaming
  task automatic test_duplicates();
    reconfigure(9'd3, 9'd2);
    send_item(CMD_CLEAR, 10'd0);
    send_item(CMD_LOAD, 10'd7);
    send_item(CMD_LOAD, 10'd7);
    send_item(CMD_LOAD, 10'd512);
    send_item(CMD_STREAM, 10'd7);
    send_item(CMD_STREAM, 10'd7);
    send_item(CMD_STREAM, 10'd7);
    send_item(CMD_STREAM, 10'd512);
    send_item(CMD_STREAM, 10'd7);
    send_item(CMD_STREAM, 10'd512);
    send_item(CMD_STREAM, 10'd7);
    send_item(CMD_LOAD, 10'd300);          // need appears while the window is full
    send_item(CMD_STREAM, 10'd300);
    send_item(CMD_STREAM, 10'd300);
  endtask

  // length zero acts as one, min zero makes every window good
  task automatic test_length_zero();
    reconfigure(9'd0, 9'd0);
    send_item(CMD_CLEAR, 10'd0);
    send_item(CMD_STREAM, 10'h155);
    send_item(CMD_STREAM, 10'h2aa);
    send_item(CMD_STREAM, 10'h3ff);
  endtask

  // need count saturates, full-size windows, oversize lengths clamp
  task automatic test_need_saturation();
    reconfigure(9'd511, 9'd256);
    steady <= 1'b1;
    send_item(CMD_CLEAR, 10'd0);
    repeat (515) send_item(CMD_LOAD, 10'h2aa);
    repeat (260) send_item(CMD_STREAM, 10'h2aa);
    steady <= 1'b0;
    reconfigure(9'd256, 9'd511);
    send_item(CMD_LOAD, 10'h2aa);
    repeat (3) send_item(CMD_STREAM, 10'h155);
    repeat (3) send_item(CMD_STREAM, 10'h2aa);
    reconfigure(9'd257, 9'd0);
    repeat (4) send_item(CMD_STREAM, 10'h2aa);
  endtask

  // length changed with no clear in between: counts drift by design
  task automatic test_resize_midstream();
    reconfigure(9'd8, 9'd3);
    send_item(CMD_CLEAR, 10'd0);
    for (int i = 0; i < 4; i++) send_item(CMD_LOAD, 10'(i * 97));
    repeat (20) send_item(CMD_STREAM, 10'($urandom_range(0, 3) * 97));
    reconfigure(9'd2, 9'd1);
    repeat (20) send_item(CMD_STREAM, 10'($urandom_range(0, 4) * 97));
    reconfigure(9'd12, 9'd4);
    repeat (30) send_item(CMD_STREAM, 10'($urandom_range(0, 4) * 97));
  endtask

  // phases: optional new settings, clear, reference loads, then a stream
  // mostly drawn from the loaded values with some noise mixed in
  task automatic test_random();
    int               pool [8];
    int               pool_n;
    int               span;
    int               r;
    int               start;
    int               phase;
    logic [CFG_W-1:0] len_sel;
    logic [CFG_W-1:0] min_sel;
    start = sent;
    phase = 0;
    span  = 1;
    while (sent - start < RANDOM_ITEMS) begin
      steady <= (phase == 3);
      if (phase == 0 || $urandom_range(0, 9) < 6) begin
        r = $urandom_range(0, 39);
        if (r == 0) len_sel = 9'd0;
        else if (r == 1) len_sel = 9'd256;
        else if (r == 2) len_sel = 9'd511;
        else if (r < 8) len_sel = 9'($urandom_range(20, 64));
        else len_sel = 9'($urandom_range(1, 12));
        span = (len_sel == 0) ? 1 : (len_sel > WINDOW_MAX) ? WINDOW_MAX : int'(len_sel);
        r = $urandom_range(0, 19);
        if (r == 0) min_sel = 9'd0;
        else if (r == 1) min_sel = 9'd511;
        else if (r == 2) min_sel = 9'd256;
        else min_sel = 9'($urandom_range(0, span + 1));
        reconfigure(len_sel, min_sel);
      end
      if ($urandom_range(0, 99) < 85) send_item(CMD_CLEAR, 10'($urandom_range(0, 1023)));
      pool_n = $urandom_range(1, 8);
      for (int i = 0; i < pool_n; i++) pool[i] = $urandom_range(0, TABLE_DEPTH - 1);
      // now and then stream with nothing loaded
      if ($urandom_range(0, 9) != 0) begin
        for (int i = 0; i < pool_n; i++) begin
          repeat ($urandom_range(1, 3)) send_item(CMD_LOAD, 10'(pool[i]));
        end
      end
      repeat (span + $urandom_range(5, 60)) begin
        r = $urandom_range(0, 99);
        if (r < 3) send_item(CMD_SPARE, 10'($urandom_range(0, 1023)));
        else if (r < 5) send_item(CMD_LOAD, 10'(pool[$urandom_range(0, pool_n - 1)]));
        else if (r < 7) send_item(CMD_LOAD, 10'($urandom_range(0, 1023)));
        else if (r < 8) send_item(CMD_CLEAR, 10'($urandom_range(0, 1023)));
        else if (r < 80) send_item(CMD_STREAM, 10'(pool[$urandom_range(0, pool_n - 1)]));
        else send_item(CMD_STREAM, 10'($urandom_range(0, 1023)));
      end
      phase++;
    end
    steady <= 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_basics();
    test_duplicates();
    test_length_zero();
    test_need_saturation();
    test_resize_midstream();
    test_random();
    settle();
    if (pending_windows.size() != 0)
      log_error($sformatf("%0d windows never reported", pending_windows.size()));
    $display("covered %0d items: %0d stream, %0d load, %0d clear, %0d ignored",
             n_stream + n_load + n_clear + n_spare, n_stream, n_load, n_clear, n_spare);
    $display("checked %0d window results, %0d good, %0d mismatches",
             n_windows, n_good, fault_count);
    if (fault_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/swmm_pkg.sv
sv/swmm_ram.sv
sv/swmm_count_unit.sv
sv/sliding_window_multiset_match_unit.sv
test/testbench.sv
